// ----- rtl/math_keyword_substituter_defines.svh -----
// ----------------------------------------------------------------------------
// Math keyword substituter assertion macros
// Concurrent assertion wrappers, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MATH_KEYWORD_SUBSTITUTER_DEFINES_SVH
`define MATH_KEYWORD_SUBSTITUTER_DEFINES_SVH
`ifndef SYNTHESIS
`define MKS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MKS_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define MKS_ASSERT(lbl, clk, rst, prop, msg)
`define MKS_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ----- rtl/mks_pkg.sv -----
// ----------------------------------------------------------------------------
// Math keyword substituter package
// Character constants, token types and the function name table.
// ----------------------------------------------------------------------------
package mks_pkg;

   localparam int WinDepth   = 5;
   localparam int WinCntW    = $clog2(WinDepth + 1);
   localparam int NameCount  = 19;
   localparam int NameMaxLen = 5;
   localparam int NameIdxW   = $clog2(NameCount);
   localparam int NameLenW   = 3;
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   typedef logic [7:0] char_type;

   localparam char_type ChOpenParen = 8'h28;
   localparam char_type ChMinus     = 8'h2D;
   localparam char_type ChZero      = 8'h30;
   localparam char_type ChSpace     = 8'h20;
   localparam char_type ChUpperA    = 8'h41;
   localparam char_type ChUpperZ    = 8'h5A;
   localparam char_type CaseOffset  = 8'h20;

   typedef struct packed {
      char_type ch;
      logic     last;
   } token_type;

   typedef logic [0:WinDepth-1][7:0] window_type;

   typedef struct packed {
      logic [NameLenW-1:0]          len;
      char_type                     code;
      logic [0:NameMaxLen-1][7:0]   text;
   } name_type;

   typedef struct packed {
      logic                hit;
      char_type            code;
      logic [NameLenW-1:0] len;
   } match_type;

   function automatic name_type name_entry(input logic [NameIdxW-1:0] k);
      name_type r;
      case (k)
         5'd0:    r = '{3'd3, "S", {"sin",   16'h0000}};
         5'd1:    r = '{3'd3, "C", {"cos",   16'h0000}};
         5'd2:    r = '{3'd4, "B", {"asin",  8'h00}};
         5'd3:    r = '{3'd4, "A", {"acos",  8'h00}};
         5'd4:    r = '{3'd4, "D", {"atan",  8'h00}};
         5'd5:    r = '{3'd4, "F", {"ceil",  8'h00}};
         5'd6:    r = '{3'd2, "J", {"ch",    24'h000000}};
         5'd7:    r = '{3'd3, "H", {"exp",   16'h0000}};
         5'd8:    r = '{3'd3, "I", {"abs",   16'h0000}};
         5'd9:    r = '{3'd5, "K", "floor"};
         5'd10:   r = '{3'd2, "G", {"ln",    24'h000000}};
         5'd11:   r = '{3'd3, "O", {"log",   16'h0000}};
         5'd12:   r = '{3'd2, "T", {"sh",    24'h000000}};
         5'd13:   r = '{3'd4, "Y", {"sqrt",  8'h00}};
         5'd14:   r = '{3'd3, "V", {"tan",   16'h0000}};
         5'd15:   r = '{3'd2, "W", {"th",    24'h000000}};
         5'd16:   r = '{3'd3, "M", {"ctg",   16'h0000}};
         5'd17:   r = '{3'd4, "N", {"actg",  8'h00}};
         5'd18:   r = '{3'd3, "P", {"cth",   16'h0000}};
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic match_type head_match(input window_type win,
                                            input logic [WinCntW-1:0] avail);
      match_type m;
      name_type  ent;
      logic      hit;
      m = '0;
      for (int k = NameCount - 1; k >= 0; k--) begin
         ent = name_entry(NameIdxW'(k));
         hit = (ent.len != '0) && (WinCntW'(ent.len) <= avail);
         for (int j = 0; j < NameMaxLen; j++) begin
            if ((NameLenW'(j) < ent.len) && (win[j] != ent.text[j])) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            m.hit  = 1'b1;
            m.code = ent.code;
            m.len  = ent.len;
         end
      end
      return m;
   endfunction

endpackage

// ----- rtl/mks_ifs.sv -----
// ----------------------------------------------------------------------------
// Math keyword substituter channel interfaces
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface mks_req_if import mks_pkg::*; ();
   logic     valid;
   logic     ready;
   char_type char_in;
   logic     is_final;
   modport source (output valid, char_in, is_final, input ready);
   modport sink   (input valid, char_in, is_final, output ready);
endinterface

interface mks_rsp_if import mks_pkg::*; ();
   logic     valid;
   logic     ready;
   char_type char_out;
   logic     end_of_text;
   modport source (output valid, char_out, end_of_text, input ready);
   modport sink   (input valid, char_out, end_of_text, output ready);
endinterface

// ----- rtl/mks_front.sv -----
// ----------------------------------------------------------------------------
// Math keyword substituter front end
// Folds case, inserts a zero after an open bracket before a minus sign.
// ----------------------------------------------------------------------------
module mks_front import mks_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mks_req_if.sink   req_bus,
   output logic      tok_valid,
   output token_type tok,
   input  logic      tok_ready
);

   logic      prev_paren_ff, prev_paren_in;
   logic      hold_valid_ff, hold_valid_in;
   token_type hold_tok_ff, hold_tok_in;
   char_type  folded;
   logic      need_zero;
   logic      accept;

   always_comb begin
      folded = req_bus.char_in;
      if ((req_bus.char_in >= ChUpperA) && (req_bus.char_in <= ChUpperZ)) begin
         folded = req_bus.char_in + CaseOffset;
      end
   end

   assign need_zero     = (folded == ChMinus) && prev_paren_ff;
   assign req_bus.ready = tok_ready && !hold_valid_ff;
   assign accept        = req_bus.valid && req_bus.ready;
   assign tok_valid     = hold_valid_ff || req_bus.valid;

   always_comb begin
      if (hold_valid_ff) begin
         tok = hold_tok_ff;
      end else if (need_zero) begin
         tok = '{ChZero, 1'b0};
      end else begin
         tok = '{folded, req_bus.is_final};
      end
   end

   always_comb begin
      prev_paren_in = prev_paren_ff;
      hold_valid_in = hold_valid_ff;
      hold_tok_in   = hold_tok_ff;
      if (hold_valid_ff && tok_ready) begin
         hold_valid_in = 1'b0;
      end
      if (accept) begin
         prev_paren_in = !req_bus.is_final && (folded == ChOpenParen);
         if (need_zero) begin
            hold_valid_in = 1'b1;
            hold_tok_in   = '{folded, req_bus.is_final};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_paren_ff <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         prev_paren_ff <= prev_paren_in;
         hold_valid_ff <= hold_valid_in;
      end
      hold_tok_ff <= hold_tok_in;
   end

endmodule

// ----- rtl/mks_queue.sv -----
// ----------------------------------------------------------------------------
// Math keyword substituter token queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
`include "math_keyword_substituter_defines.svh"

module mks_queue import mks_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  token_type push_tok,
   output logic      push_ready,
   output logic      pop_valid,
   output token_type pop_tok,
   input  logic      pop_ready
);

   token_type              mem_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;
   logic                   push, pop;

   assign push_ready = (count_ff != QueueCntW'(QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_tok    = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_tok;
      end
   end

   `MKS_ASSERT(a_queue_bound, clock, reset, count_ff <= QueueCntW'(QueueDepth), "queue overfilled")
   `MKS_ASSERT_NEVER(a_queue_pop_empty, clock, reset, pop && (count_ff == '0), "pop from empty queue")

endmodule

// ----- rtl/mks_back.sv -----
// ----------------------------------------------------------------------------
// Math keyword substituter back end
// Five-character window, name matching, blanking and the output register.
// ----------------------------------------------------------------------------
`include "math_keyword_substituter_defines.svh"

module mks_back import mks_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      tok_valid,
   input  token_type tok,
   output logic      tok_ready,
   mks_rsp_if.source rsp_bus
);

   window_type          win_ff, win_in, win_shift;
   logic [WinCntW-1:0]  cnt_ff, cnt_in, cnt_after;
   logic [NameLenW-1:0] blank_ff, blank_in;
   logic                flush_ff, flush_in;
   logic                rsp_valid_ff, rsp_valid_in;
   char_type            rsp_char_ff, rsp_char_in;
   logic                rsp_end_ff, rsp_end_in;
   match_type           match;
   logic                out_free, want_emit, emit, emit_last, take;
   char_type            emit_char;

   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign want_emit = (cnt_ff == WinCntW'(WinDepth)) || (flush_ff && (cnt_ff != '0));
   assign emit      = want_emit && out_free;
   assign emit_last = flush_ff && (cnt_ff == WinCntW'(1));
   assign tok_ready = !flush_ff && ((cnt_ff != WinCntW'(WinDepth)) || emit);
   assign take      = tok_valid && tok_ready;
   assign match     = head_match(win_ff, cnt_ff);

   always_comb begin
      if (blank_ff != '0) begin
         emit_char = ChSpace;
      end else if (match.hit) begin
         emit_char = match.code;
      end else begin
         emit_char = win_ff[0];
      end
   end

   always_comb begin
      win_shift = win_ff;
      cnt_after = cnt_ff;
      if (emit) begin
         for (int i = 0; i < WinDepth - 1; i++) begin
            win_shift[i] = win_ff[i+1];
         end
         cnt_after = cnt_ff - 1'b1;
      end
      win_in = win_shift;
      cnt_in = cnt_after;
      if (take) begin
         for (int i = 0; i < WinDepth; i++) begin
            if (cnt_after == WinCntW'(i)) begin
               win_in[i] = tok.ch;
            end
         end
         cnt_in = cnt_after + 1'b1;
      end
   end

   always_comb begin
      blank_in = blank_ff;
      flush_in = flush_ff;
      if (emit) begin
         if (blank_ff != '0) begin
            blank_in = blank_ff - 1'b1;
         end else if (match.hit) begin
            blank_in = match.len - 1'b1;
         end
      end
      if (take && tok.last) begin
         flush_in = 1'b1;
      end
      if (emit && emit_last) begin
         flush_in = 1'b0;
         blank_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_end_in   = rsp_end_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = emit_char;
         rsp_end_in   = emit_last;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         blank_ff     <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         blank_ff     <= blank_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      win_ff      <= win_in;
      rsp_char_ff <= rsp_char_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.char_out    = rsp_char_ff;
   assign rsp_bus.end_of_text = rsp_end_ff;

   `MKS_ASSERT(a_win_bound, clock, reset, cnt_ff <= WinCntW'(WinDepth), "window overfilled")
   `MKS_ASSERT(a_blank_in_window, clock, reset, WinCntW'(blank_ff) <= cnt_ff, "blanking beyond window")
   `MKS_ASSERT(a_flush_done, clock, reset, (emit && emit_last) |=> ((cnt_ff == '0) && !flush_ff), "window not empty after last item")

endmodule

// ----- rtl/math_keyword_substituter.sv -----
// ----------------------------------------------------------------------------
// Math keyword substituter
// Rewrites an expression character stream: case folding, zero insertion and
// replacement of function names by code letters padded with spaces.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one character per item with is_final on the last one of
//   an expression; rsp_bus returns the rewritten characters in order, with
//   end_of_text on the last character of the expression.
//   The front end takes one item per cycle while the queue has room; for an
//   item that needs a zero inserted ahead of it, it sends the zero, holds the
//   item and takes no new item until the held one has gone on. The back end
//   gives one character per cycle while the output register is free, from a
//   five-character window, so a character leaves once four more follow it,
//   or during the flush that a final item starts, which sends out every
//   character still held (up to five) and blocks new items until done.
//   A four-entry queue between the two halves lets either stall alone; when
//   rsp_bus is held off, the output register and window fill, then the
//   queue, then req_bus.ready drops. Reset empties the window, the queue and
//   the output register and starts a new expression.
// ----------------------------------------------------------------------------
module math_keyword_substituter import mks_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mks_req_if.sink   req_bus,
   mks_rsp_if.source rsp_bus
);

   logic      front_valid, front_ready;
   token_type front_tok;
   logic      back_valid, back_ready;
   token_type back_tok;

   mks_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .tok_valid (front_valid),
      .tok       (front_tok),
      .tok_ready (front_ready)
   );

   mks_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_tok   (front_tok),
      .push_ready (front_ready),
      .pop_valid  (back_valid),
      .pop_tok    (back_tok),
      .pop_ready  (back_ready)
   );

   mks_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (back_valid),
      .tok       (back_tok),
      .tok_ready (back_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Math keyword substituter testbench
// Feeds expressions one character per item: a few hand-picked ones first,
// then random mixes of function names (either case, sometimes cut short),
// brackets, minus signs, digits and raw bytes. A per-item predictor of
// the rewrite builds the expected output characters, and every output
// item is checked against them in order. Both sides stall at random; once
// the receiver holds off for a long stretch, and now and then the sender
// waits for the output to drain completely.
// ----------------------------------------------------------------------------
module testbench;
   import mks_pkg::*;

   localparam int StimChars  = 480;
   localparam int HoldAt     = 150;
   localparam int HoldCycles = 400;
   localparam int CycleLimit = 400000;
   localparam int TailCycles = 20;

   typedef struct {
      char_type ch;
      logic     fin;
      bit       drain;
   } stim_item;

   typedef struct {
      char_type ch;
      logic     last;
   } out_char;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mks_req_if req_bus ();
   mks_rsp_if rsp_bus ();

   math_keyword_substituter u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   stim_item expr_chars[$];
   out_char  rewritten_chars[$];

   int  errors       = 0;
   int  cycle_count  = 0;
   int  results_seen = 0;
   int  hold_left    = 0;
   bit  req_fire     = 1'b0;
   bit  rsp_fire     = 1'b0;

   // predictor state
   char_type held_chars[4];
   int       held_count  = 0;
   int       blank_left  = 0;
   bit       after_paren = 1'b0;

   task automatic report_mismatch(input string msg);
      $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
      errors++;
   endtask

   function automatic void keyword(input int k, output logic [39:0] txt,
                                   output int len, output char_type code);
      case (k)
         0:       begin txt = "sin";   len = 3; code = "S"; end
         1:       begin txt = "cos";   len = 3; code = "C"; end
         2:       begin txt = "asin";  len = 4; code = "B"; end
         3:       begin txt = "acos";  len = 4; code = "A"; end
         4:       begin txt = "atan";  len = 4; code = "D"; end
         5:       begin txt = "ceil";  len = 4; code = "F"; end
         6:       begin txt = "ch";    len = 2; code = "J"; end
         7:       begin txt = "exp";   len = 3; code = "H"; end
         8:       begin txt = "abs";   len = 3; code = "I"; end
         9:       begin txt = "floor"; len = 5; code = "K"; end
         10:      begin txt = "ln";    len = 2; code = "G"; end
         11:      begin txt = "log";   len = 3; code = "O"; end
         12:      begin txt = "sh";    len = 2; code = "T"; end
         13:      begin txt = "sqrt";  len = 4; code = "Y"; end
         14:      begin txt = "tan";   len = 3; code = "V"; end
         15:      begin txt = "th";    len = 2; code = "W"; end
         16:      begin txt = "ctg";   len = 3; code = "M"; end
         17:      begin txt = "actg";  len = 4; code = "N"; end
         default: begin txt = "cth";   len = 3; code = "P"; end
      endcase
   endfunction

   task automatic rewrite_char(input char_type raw, input logic fin);
      char_type    seq[6];
      char_type    c;
      char_type    head;
      char_type    code;
      logic [39:0] txt;
      int          n;
      int          pos;
      int          len;
      bit          found;
      bit          hit;
      c = raw;
      if (c >= ChUpperA && c <= ChUpperZ) c = c + CaseOffset;
      n = held_count;
      for (int i = 0; i < n; i++) seq[i] = held_chars[i];
      if (c == ChMinus && after_paren) begin
         seq[n] = ChZero;
         n++;
      end
      seq[n] = c;
      n++;
      after_paren = (c == ChOpenParen);
      pos = 0;
      while ((n - pos) >= 5 || (fin && pos < n)) begin
         if (blank_left > 0) begin
            blank_left--;
            head = ChSpace;
         end else begin
            head  = seq[pos];
            found = 1'b0;
            for (int k = 0; k < 19; k++) begin
               keyword(k, txt, len, code);
               if (!found && pos + len <= n) begin
                  hit = 1'b1;
                  for (int j = 0; j < len; j++) begin
                     if (seq[pos + j] != txt[8 * (len - 1 - j) +: 8]) hit = 1'b0;
                  end
                  if (hit) begin
                     found      = 1'b1;
                     head       = code;
                     blank_left = len - 1;
                  end
               end
            end
         end
         rewritten_chars.push_back('{head, fin && (pos == n - 1)});
         pos++;
      end
      if (fin) begin
         for (int i = 0; i < 4; i++) held_chars[i] = '0;
         held_count  = 0;
         blank_left  = 0;
         after_paren = 1'b0;
      end else begin
         held_count = n - pos;
         for (int i = 0; i < 4; i++) held_chars[i] = (i < held_count) ? seq[pos + i] : '0;
      end
   endtask

   task automatic add_char(input char_type c, input logic fin, input bit drain);
      expr_chars.push_back('{c, fin, drain});
   endtask

   task automatic add_text(input string s, input bit fin_at_end, input bit drain);
      for (int i = 0; i < s.len(); i++) begin
         add_char(s[i], fin_at_end && (i == s.len() - 1), drain && (i == 0));
      end
   endtask

   task automatic add_expression(input bit drain);
      char_type    expr[$];
      char_type    c;
      char_type    code;
      logic [39:0] txt;
      int          tokens;
      int          kind;
      int          len;
      tokens = $urandom_range(1, 8);
      for (int t = 0; t < tokens; t++) begin
         kind = $urandom_range(0, 9);
         if (kind <= 3) begin
            keyword($urandom_range(0, 18), txt, len, code);
            if (kind == 3) len = len - 1;
            for (int j = 0; j < len; j++) begin
               c = txt[8 * (len - 1 - j + ((kind == 3) ? 1 : 0)) +: 8];
               if ($urandom_range(0, 3) == 0) c = c - CaseOffset;
               expr.push_back(c);
            end
         end else if (kind == 4) begin
            expr.push_back(ChOpenParen);
         end else if (kind == 5) begin
            expr.push_back(ChOpenParen);
            expr.push_back(ChMinus);
         end else if (kind == 6) begin
            expr.push_back(ChMinus);
         end else if (kind == 7) begin
            expr.push_back(ChZero + char_type'($urandom_range(0, 9)));
         end else if (kind == 8) begin
            c = "a" + char_type'($urandom_range(0, 25));
            if ($urandom_range(0, 1) == 0) c = c - CaseOffset;
            expr.push_back(c);
         end else begin
            expr.push_back(char_type'($urandom_range(0, 255)));
         end
      end
      for (int i = 0; i < expr.size(); i++) begin
         add_char(expr[i], i == expr.size() - 1, drain && (i == 0));
      end
   endtask

   // driver
   int send_gap  = 0;
   bit send_calm = 1'b0;

   always @(negedge clock) begin : drive_req
      stim_item it;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_fire) begin
      end else if (send_gap > 0 && hold_left == 0) begin
         req_bus.valid <= 1'b0;
         send_gap--;
      end else if (expr_chars.size() != 0 &&
                   !(expr_chars[0].drain && rewritten_chars.size() != 0)) begin
         it = expr_chars.pop_front();
         req_bus.char_in  <= it.ch;
         req_bus.is_final <= it.fin;
         req_bus.valid    <= 1'b1;
         if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
         send_gap = send_calm ? 0 : $urandom_range(0, 9);
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // receiver
   int recv_gap  = 0;
   bit recv_calm = 1'b0;

   always @(negedge clock) begin : drive_rsp
      int next_hold;
      next_hold = hold_left;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_fire) begin
            if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
            recv_gap = recv_calm ? 0 : $urandom_range(0, 9);
            if (results_seen == HoldAt) next_hold = HoldCycles;
         end
         if (next_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            next_hold--;
         end else if (recv_gap > 0) begin
            rsp_bus.ready <= 1'b0;
            recv_gap--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
      hold_left <= next_hold;
   end

   // predict and check
   always @(posedge clock) begin : check_out
      out_char want;
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("tb: failure");
         $finish;
      end else begin
         req_fire <= !reset && req_bus.valid && req_bus.ready;
         rsp_fire <= !reset && rsp_bus.valid && rsp_bus.ready;
         if (!reset && req_bus.valid && req_bus.ready) begin
            rewrite_char(req_bus.char_in, req_bus.is_final);
         end
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (rewritten_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected char_out %02h end_of_text %0b",
                                         rsp_bus.char_out, rsp_bus.end_of_text));
            end else begin
               want = rewritten_chars.pop_front();
               if (rsp_bus.char_out !== want.ch) begin
                  report_mismatch($sformatf("char_out %02h, expected %02h",
                                            rsp_bus.char_out, want.ch));
               end
               if (rsp_bus.end_of_text !== want.last) begin
                  report_mismatch($sformatf("end_of_text %0b, expected %0b",
                                            rsp_bus.end_of_text, want.last));
               end
            end
         end
      end
   end

   initial begin
      int total;
      req_bus.valid    = 1'b0;
      req_bus.char_in  = '0;
      req_bus.is_final = 1'b0;
      rsp_bus.ready    = 1'b0;
      for (int i = 0; i < 4; i++) held_chars[i] = '0;

      // upper case, name at the head, zero before a minus after a bracket
      add_text("ACOS(-Z)", 1'b1, 1'b0);
      // zero byte and top-bit bytes, then a name cut off by the end
      add_char(8'h00, 1'b0, 1'b0);
      add_char(8'hFF, 1'b0, 1'b0);
      add_char(8'h80, 1'b0, 1'b0);
      add_text("sQr", 1'b1, 1'b0);
      // name with a blanked letter, then a letter left as it is
      add_text("Chs", 1'b1, 1'b1);
      // name ending exactly on the last character
      add_text("floor", 1'b1, 1'b0);

      total = 0;
      for (int e = 0; total < StimChars; e++) begin
         int before_size;
         before_size = expr_chars.size();
         add_expression((e % 6) == 5);
         total += expr_chars.size() - before_size;
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (expr_chars.size() != 0 || req_bus.valid) @(posedge clock);
      while (rewritten_chars.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
